// File: rtl/bcrtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrtc_pkg
// types and codes shared by the bank controller with real-time clock
// ----------------------------------------------------------------------------
package bcrtc_pkg;

   // request kinds on the input channel
   typedef enum logic [1:0] {
      REQ_READ     = 2'd0,
      REQ_WRITE    = 2'd1,
      REQ_TICK_FWD = 2'd2,
      REQ_TICK_BWD = 2'd3
   } req_kind_type;

   // where an access goes
   typedef enum logic [2:0] {
      TGT_NONE  = 3'd0,
      TGT_FIXED = 3'd1,
      TGT_ROM   = 3'd2,
      TGT_RAM   = 3'd3,
      TGT_RTC   = 3'd4,
      TGT_ZERO  = 3'd5
   } target_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_HAS_RAM    = 2'd0,
      CSR_HAS_RTC    = 2'd1,
      CSR_VARIANT_30 = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam int unsigned RTC_REGS = 5;

   localparam logic [7:0] SEC_LIMIT  = 8'd60;
   localparam logic [7:0] MIN_LIMIT  = 8'd60;
   localparam logic [7:0] HOUR_LIMIT = 8'd24;
   localparam logic [7:0] SEC_TOP    = 8'd59;
   localparam logic [7:0] MIN_TOP    = 8'd59;
   localparam logic [7:0] HOUR_TOP   = 8'd23;
   localparam logic [7:0] ALL_ONES   = 8'hFF;
   localparam logic [3:0] ENABLE_KEY = 4'hA;

   typedef struct packed {
      req_kind_type req_type;
      logic [15:0]  addr;
      logic [7:0]   write_data;
   } req_beat_type;

   typedef struct packed {
      target_type  target;
      logic [6:0]  bank;
      logic [15:0] offset;
      logic [7:0]  read_data;
   } rsp_beat_type;

endpackage

// File: rtl/bank_controller_with_rtc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_controller_with_rtc
// cartridge bank controller with real-time clock, one result per request
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready/req_payload) carries cpu reads, cpu
//   writes and one-second forward or backward clock ticks
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns one beat per
//   request: target, bank, offset and read data
//   apb port sets has_ram (0x0), has_rtc (0x4), is_variant_30 (0x8);
//   write it only while no request is in flight
// pipeline and throughput
//   a request is captured in the input register, then decoded and applied
//   to the controller state once the result register can take it, and
//   its result lands in the result register, which drives rsp_valid
//   one request per cycle sustained while rsp_ready stays high; the decode
//   and clock carry chain lie between the input and result registers
// reset
//   enables, bank selects, clock, latched copies and the latch arm clear;
//   has_ram and has_rtc come up set, is_variant_30 clear
// stall
//   while rsp_ready is low the result holds; one more request waits in the
//   input register, then req_ready drops
// ----------------------------------------------------------------------------
module bank_controller_with_rtc (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bcrtc_pkg::req_beat_type req_payload,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bcrtc_pkg::rsp_beat_type rsp_payload,
   // configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // configuration registers
   logic has_ram_ff, has_rtc_ff, variant_30_ff;
   logic has_ram_in, has_rtc_in, variant_30_in;

   // input stage
   logic                    in_valid_ff, in_valid_in;
   bcrtc_pkg::req_beat_type in_beat_ff;

   // result stage
   logic                    out_valid_ff, out_valid_in;
   bcrtc_pkg::rsp_beat_type out_beat_ff, out_beat_in;

   // controller state
   logic       ram_enable_ff, ram_enable_in;
   logic       clock_enable_ff, clock_enable_in;
   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [7:0] bank_sel_ff, bank_sel_in;
   logic       latch_armed_ff, latch_armed_in;
   logic [7:0] clock_regs_ff [bcrtc_pkg::RTC_REGS];
   logic [7:0] clock_regs_in [bcrtc_pkg::RTC_REGS];
   logic [7:0] latched_ff [bcrtc_pkg::RTC_REGS];
   logic [7:0] latched_in [bcrtc_pkg::RTC_REGS];

   // handshake
   logic advance;
   logic take_beat;

   // decode helpers
   logic       ext_area;
   logic       rom_area;
   logic       ram_sel;
   logic       rtc_sel;
   logic [2:0] rtc_idx;
   logic       csr_write;
   bcrtc_pkg::csr_index_type csr_idx;

   // forward tick chain
   logic [7:0] fwd_sec, fwd_min, fwd_hour;
   logic [8:0] fwd_day;
   logic       fwd_c_min, fwd_c_hour, fwd_c_day;
   // backward tick chain
   logic [7:0] bwd_sec, bwd_min, bwd_hour;
   logic [8:0] bwd_day;
   logic       bwd_b_min, bwd_b_hour, bwd_b_day;

   // ---------------------------------------------------------------------
   // handshake: result register drains or is empty, then the input beat moves
   // ---------------------------------------------------------------------
   assign advance     = !out_valid_ff || rsp_ready;
   assign take_beat   = in_valid_ff && advance;
   assign req_ready   = !in_valid_ff || advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_beat_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take_beat) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (take_beat) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // configuration port: pready tied high, reads decode paddr directly
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_idx   = bcrtc_pkg::csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      has_ram_in    = has_ram_ff;
      has_rtc_in    = has_rtc_ff;
      variant_30_in = variant_30_ff;
      prdata        = 32'd0;
      unique case (csr_idx)
         bcrtc_pkg::CSR_HAS_RAM: begin
            prdata = {31'd0, has_ram_ff};
            if (csr_write) has_ram_in = pwdata[0];
         end
         bcrtc_pkg::CSR_HAS_RTC: begin
            prdata = {31'd0, has_rtc_ff};
            if (csr_write) has_rtc_in = pwdata[0];
         end
         bcrtc_pkg::CSR_VARIANT_30: begin
            prdata = {31'd0, variant_30_ff};
            if (csr_write) variant_30_in = pwdata[0];
         end
         default: begin
            prdata = 32'd0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // clock tick chains, both directions, from the running registers
   // ---------------------------------------------------------------------
   always_comb begin
      // forward: seconds, minutes and hours snap out of range values to zero and carry
      fwd_sec   = clock_regs_ff[0] + 8'd1;
      fwd_c_min = (fwd_sec >= bcrtc_pkg::SEC_LIMIT);
      if (fwd_c_min) fwd_sec = 8'd0;
      fwd_min    = clock_regs_ff[1] + {7'd0, fwd_c_min};
      fwd_c_hour = (fwd_min >= bcrtc_pkg::MIN_LIMIT);
      if (fwd_c_hour) fwd_min = 8'd0;
      fwd_hour  = clock_regs_ff[2] + {7'd0, fwd_c_hour};
      fwd_c_day = (fwd_hour >= bcrtc_pkg::HOUR_LIMIT);
      if (fwd_c_day) fwd_hour = 8'd0;
      fwd_day = {clock_regs_ff[4][0], clock_regs_ff[3]} + {8'd0, fwd_c_day};

      // backward: all-ones after the decrement means a borrow
      bwd_sec   = clock_regs_ff[0] - 8'd1;
      bwd_b_min = (bwd_sec == bcrtc_pkg::ALL_ONES);
      if (bwd_b_min) bwd_sec = bcrtc_pkg::SEC_TOP;
      bwd_min    = clock_regs_ff[1] - {7'd0, bwd_b_min};
      bwd_b_hour = (bwd_min == bcrtc_pkg::ALL_ONES);
      if (bwd_b_hour) bwd_min = bcrtc_pkg::MIN_TOP;
      bwd_hour  = clock_regs_ff[2] - {7'd0, bwd_b_hour};
      bwd_b_day = (bwd_hour == bcrtc_pkg::ALL_ONES);
      if (bwd_b_day) bwd_hour = bcrtc_pkg::HOUR_TOP;
      bwd_day = {clock_regs_ff[4][0], clock_regs_ff[3]} - {8'd0, bwd_b_day};
   end

   // ---------------------------------------------------------------------
   // access decode
   // ---------------------------------------------------------------------
   assign ext_area = (in_beat_ff.addr[15:13] == 3'b101);   // external ram window
   assign rom_area = (in_beat_ff.addr[15:14] == 2'b01);    // switchable rom window
   assign ram_sel  = ram_enable_ff &&
                     (variant_30_ff ? (bank_sel_ff < 8'd8) : (bank_sel_ff <= 8'd3));
   assign rtc_sel  = clock_enable_ff && (bank_sel_ff >= 8'd8) && (bank_sel_ff <= 8'd12);
   // selector 8..12 maps to clock register 0..4 by its low bits
   assign rtc_idx  = bank_sel_ff[2:0];

   always_comb begin
      ram_enable_in   = ram_enable_ff;
      clock_enable_in = clock_enable_ff;
      rom_bank_in     = rom_bank_ff;
      bank_sel_in     = bank_sel_ff;
      latch_armed_in  = latch_armed_ff;
      clock_regs_in   = clock_regs_ff;
      latched_in      = latched_ff;
      out_beat_in     = out_beat_ff;

      if (take_beat) begin
         out_beat_in.target    = bcrtc_pkg::TGT_NONE;
         out_beat_in.bank      = 7'd0;
         out_beat_in.offset    = 16'd0;
         out_beat_in.read_data = 8'd0;

         unique case (in_beat_ff.req_type)
            bcrtc_pkg::REQ_READ: begin
               priority if (rom_area) begin
                  if (rom_bank_ff >= 7'd2) begin
                     out_beat_in.target = bcrtc_pkg::TGT_ROM;
                     out_beat_in.bank   = rom_bank_ff - 7'd2;
                     out_beat_in.offset = {2'b00, in_beat_ff.addr[13:0]};
                  end else begin
                     out_beat_in.target = bcrtc_pkg::TGT_FIXED;
                     out_beat_in.offset = in_beat_ff.addr;
                  end
               end else if (ext_area) begin
                  priority if (ram_sel) begin
                     out_beat_in.target = bcrtc_pkg::TGT_RAM;
                     out_beat_in.bank   = bank_sel_ff[6:0];
                     out_beat_in.offset = {3'b000, in_beat_ff.addr[12:0]};
                  end else if (rtc_sel) begin
                     out_beat_in.target    = bcrtc_pkg::TGT_RTC;
                     out_beat_in.read_data = latched_ff[rtc_idx];
                  end else begin
                     out_beat_in.target = bcrtc_pkg::TGT_ZERO;
                  end
               end else begin
                  out_beat_in.target = bcrtc_pkg::TGT_FIXED;
                  out_beat_in.offset = in_beat_ff.addr;
               end
            end

            bcrtc_pkg::REQ_WRITE: begin
               priority if (ext_area) begin
                  priority if (ram_sel) begin
                     out_beat_in.target = bcrtc_pkg::TGT_RAM;
                     out_beat_in.bank   = bank_sel_ff[6:0];
                     out_beat_in.offset = {3'b000, in_beat_ff.addr[12:0]};
                  end else if (rtc_sel) begin
                     out_beat_in.target     = bcrtc_pkg::TGT_RTC;
                     clock_regs_in[rtc_idx] = in_beat_ff.write_data;
                  end else begin
                     out_beat_in.target = bcrtc_pkg::TGT_NONE;
                  end
               end else if (in_beat_ff.addr[15:13] == 3'b000) begin
                  // enable key opens whatever the cartridge carries
                  if (in_beat_ff.write_data[3:0] == bcrtc_pkg::ENABLE_KEY) begin
                     if (has_ram_ff) ram_enable_in = 1'b1;
                     if (has_rtc_ff) clock_enable_in = 1'b1;
                  end else begin
                     ram_enable_in   = 1'b0;
                     clock_enable_in = 1'b0;
                  end
               end else if (in_beat_ff.addr[15:13] == 3'b001) begin
                  rom_bank_in = in_beat_ff.write_data[6:0];
               end else if (in_beat_ff.addr[15:13] == 3'b010) begin
                  bank_sel_in = in_beat_ff.write_data;
               end else if (in_beat_ff.addr[15:13] == 3'b011) begin
                  // latch sequence: zero arms, then one copies the clock
                  if (clock_enable_ff) begin
                     priority if (!latch_armed_ff && (in_beat_ff.write_data == 8'd0)) begin
                        latch_armed_in = 1'b1;
                     end else if (latch_armed_ff && (in_beat_ff.write_data == 8'd1)) begin
                        latched_in     = clock_regs_ff;
                        latch_armed_in = 1'b0;
                     end else begin
                        latch_armed_in = latch_armed_ff;
                     end
                  end
               end else begin
                  out_beat_in.target = bcrtc_pkg::TGT_NONE;
               end
            end

            bcrtc_pkg::REQ_TICK_FWD: begin
               clock_regs_in[0] = fwd_sec;
               clock_regs_in[1] = fwd_min;
               clock_regs_in[2] = fwd_hour;
               clock_regs_in[3] = fwd_day[7:0];
               clock_regs_in[4] = {clock_regs_ff[4][7:1], fwd_day[8]};
            end

            bcrtc_pkg::REQ_TICK_BWD: begin
               clock_regs_in[0] = bwd_sec;
               clock_regs_in[1] = bwd_min;
               clock_regs_in[2] = bwd_hour;
               clock_regs_in[3] = bwd_day[7:0];
               clock_regs_in[4] = {clock_regs_ff[4][7:1], bwd_day[8]};
            end

            default: begin
               out_beat_in.target = bcrtc_pkg::TGT_NONE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         has_ram_ff      <= 1'b1;
         has_rtc_ff      <= 1'b1;
         variant_30_ff   <= 1'b0;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         ram_enable_ff   <= 1'b0;
         clock_enable_ff <= 1'b0;
         rom_bank_ff     <= 7'd0;
         bank_sel_ff     <= 8'd0;
         latch_armed_ff  <= 1'b0;
         for (int i = 0; i < bcrtc_pkg::RTC_REGS; i++) begin
            clock_regs_ff[i] <= 8'd0;
            latched_ff[i]    <= 8'd0;
         end
      end else begin
         has_ram_ff      <= has_ram_in;
         has_rtc_ff      <= has_rtc_in;
         variant_30_ff   <= variant_30_in;
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         ram_enable_ff   <= ram_enable_in;
         clock_enable_ff <= clock_enable_in;
         rom_bank_ff     <= rom_bank_in;
         bank_sel_ff     <= bank_sel_in;
         latch_armed_ff  <= latch_armed_in;
         clock_regs_ff   <= clock_regs_in;
         latched_ff      <= latched_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_beat_ff <= req_payload;
      end
      out_beat_ff <= out_beat_in;
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// bank controller with real-time clock: every access and tick is predicted
// ----------------------------------------------------------------------------
// cpu reads, cpu writes and clock ticks in on the request channel
// a cycle-free copy of the controller state predicts each accepted beat
// each result beat checked field by field against the oldest prediction
// directed cases first: bank mapping, enables, two-step latch, clock carry
// and borrow, day wrap
// then random traffic under every setting of the cartridge options, with a
// streaming stretch and a long result stall
// ----------------------------------------------------------------------------
module testbench;

   localparam int RSP_HOLD_CYCLES = 200;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   bcrtc_pkg::req_beat_type req_payload = '0;

   // result channel
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   bcrtc_pkg::rsp_beat_type rsp_payload;

   // apb port
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [3:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // run control
   int fail_count    = 0;
   bit calm          = 1'b0;   // no idling on either side while set
   bit hold_request  = 1'b0;   // asks the receiver for one long stall

   // predicted results, oldest first
   bcrtc_pkg::rsp_beat_type pending_results[$];

   // predicted controller state and cartridge options
   bit         opt_ram_fitted   = 1'b1;
   bit         opt_clock_fitted = 1'b1;
   bit         opt_eight_banks  = 1'b0;
   bit         ram_on           = 1'b0;
   bit         clock_on         = 1'b0;
   logic [6:0] rom_sel          = '0;
   logic [7:0] ext_sel          = '0;
   logic [7:0] rtc_live [bcrtc_pkg::RTC_REGS] = '{default: 8'd0};
   logic [7:0] rtc_held [bcrtc_pkg::RTC_REGS] = '{default: 8'd0};
   bit         latch_armed      = 1'b0;

   bank_controller_with_rtc DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // 9-bit day count: day low byte plus bit 0 of the day high register
   function automatic void step_day(bit up);
      logic [8:0] day;
      day = {rtc_live[4][0], rtc_live[3]};
      day = up ? day + 9'd1 : day - 9'd1;
      rtc_live[3]    = day[7:0];
      rtc_live[4][0] = day[8];
   endfunction

   // each compare runs on every tick, so out of range values snap at once
   function automatic void advance_clock();
      rtc_live[0] = rtc_live[0] + 8'd1;
      if (rtc_live[0] >= bcrtc_pkg::SEC_LIMIT) begin
         rtc_live[0] = 8'd0;
         rtc_live[1] = rtc_live[1] + 8'd1;
      end
      if (rtc_live[1] >= bcrtc_pkg::MIN_LIMIT) begin
         rtc_live[1] = 8'd0;
         rtc_live[2] = rtc_live[2] + 8'd1;
      end
      if (rtc_live[2] >= bcrtc_pkg::HOUR_LIMIT) begin
         rtc_live[2] = 8'd0;
         step_day(1'b1);
      end
   endfunction

   function automatic void rewind_clock();
      rtc_live[0] = rtc_live[0] - 8'd1;
      if (rtc_live[0] == bcrtc_pkg::ALL_ONES) begin
         rtc_live[0] = bcrtc_pkg::SEC_TOP;
         rtc_live[1] = rtc_live[1] - 8'd1;
      end
      if (rtc_live[1] == bcrtc_pkg::ALL_ONES) begin
         rtc_live[1] = bcrtc_pkg::MIN_TOP;
         rtc_live[2] = rtc_live[2] - 8'd1;
      end
      if (rtc_live[2] == bcrtc_pkg::ALL_ONES) begin
         rtc_live[2] = bcrtc_pkg::HOUR_TOP;
         step_day(1'b0);
      end
   endfunction

   function automatic bit ram_window();
      if (!ram_on) return 1'b0;
      return opt_eight_banks ? (ext_sel < 8'd8) : (ext_sel <= 8'd3);
   endfunction

   function automatic bit clock_window();
      return clock_on && ext_sel >= 8'd8 && ext_sel <= 8'd12;
   endfunction

   // result of one request, applying its side effects to the state copy
   function automatic bcrtc_pkg::rsp_beat_type predict_access(bcrtc_pkg::req_beat_type b);
      bcrtc_pkg::rsp_beat_type r;
      bit                      in_ext;
      int                      idx;
      r      = '0;
      in_ext = (b.addr >= 16'hA000 && b.addr <= 16'hBFFF);
      idx    = int'(ext_sel) - 8;
      case (b.req_type)
         bcrtc_pkg::REQ_READ: begin
            if (b.addr >= 16'h4000 && b.addr <= 16'h7FFF) begin
               if (rom_sel >= 7'd2) begin
                  r.target = bcrtc_pkg::TGT_ROM;
                  r.bank   = rom_sel - 7'd2;
                  r.offset = b.addr - 16'h4000;
               end else begin
                  r.target = bcrtc_pkg::TGT_FIXED;
                  r.offset = b.addr;
               end
            end else if (in_ext) begin
               if (ram_window()) begin
                  r.target = bcrtc_pkg::TGT_RAM;
                  r.bank   = ext_sel[6:0];
                  r.offset = b.addr - 16'hA000;
               end else if (clock_window()) begin
                  r.target    = bcrtc_pkg::TGT_RTC;
                  r.read_data = rtc_held[idx];
               end else begin
                  r.target = bcrtc_pkg::TGT_ZERO;
               end
            end else begin
               r.target = bcrtc_pkg::TGT_FIXED;
               r.offset = b.addr;
            end
         end
         bcrtc_pkg::REQ_WRITE: begin
            if (in_ext) begin
               if (ram_window()) begin
                  r.target = bcrtc_pkg::TGT_RAM;
                  r.bank   = ext_sel[6:0];
                  r.offset = b.addr - 16'hA000;
               end else if (clock_window()) begin
                  r.target      = bcrtc_pkg::TGT_RTC;
                  rtc_live[idx] = b.write_data;
               end
            end else if (b.addr <= 16'h1FFF) begin
               // a missing part keeps its enable as it was
               if (b.write_data[3:0] == bcrtc_pkg::ENABLE_KEY) begin
                  if (opt_ram_fitted) ram_on = 1'b1;
                  if (opt_clock_fitted) clock_on = 1'b1;
               end else begin
                  ram_on   = 1'b0;
                  clock_on = 1'b0;
               end
            end else if (b.addr <= 16'h3FFF) begin
               rom_sel = b.write_data[6:0];
            end else if (b.addr <= 16'h5FFF) begin
               ext_sel = b.write_data;
            end else if (b.addr <= 16'h7FFF) begin
               // latch copies only on 0 then 1
               if (clock_on) begin
                  if (!latch_armed && b.write_data == 8'd0) begin
                     latch_armed = 1'b1;
                  end else if (latch_armed && b.write_data == 8'd1) begin
                     rtc_held    = rtc_live;
                     latch_armed = 1'b0;
                  end
               end
            end
         end
         bcrtc_pkg::REQ_TICK_FWD: advance_clock();
         default:                 rewind_clock();
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one beat, hold it until accepted, then maybe idle a little
   task automatic send_req(bcrtc_pkg::req_kind_type kind, logic [15:0] addr,
                           logic [7:0] data);
      bcrtc_pkg::req_beat_type b;
      b.req_type   = kind;
      b.addr       = addr;
      b.write_data = data;
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_access(b));
      if (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // mostly well-formed bus traffic aimed at each register window
   task automatic send_random();
      int          pick;
      logic [7:0]  data;
      pick = $urandom_range(99);
      data = 8'($urandom_range(255));
      if (pick < 10) begin
         // enable key with random upper nibble, or a clearing value
         if ($urandom_range(3) != 0) data[3:0] = bcrtc_pkg::ENABLE_KEY;
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'h1FFF)), data);
      end else if (pick < 17) begin
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'h3FFF, 16'h2000)), data);
      end else if (pick < 26) begin
         if ($urandom_range(9) < 7) data = 8'($urandom_range(12));
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'h5FFF, 16'h4000)), data);
      end else if (pick < 32) begin
         // latch arm then copy
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'h7FFF, 16'h6000)), 8'd0);
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'h7FFF, 16'h6000)), 8'd1);
      end else if (pick < 35) begin
         if ($urandom_range(1) == 0) data = 8'($urandom_range(1));
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'h7FFF, 16'h6000)), data);
      end else if (pick < 45) begin
         // clock bytes near their limits so carries and borrows happen
         case ($urandom_range(7))
            0: data = 8'd0;
            1: data = bcrtc_pkg::SEC_TOP;
            2: data = bcrtc_pkg::SEC_LIMIT;
            3: data = bcrtc_pkg::HOUR_TOP;
            4: data = bcrtc_pkg::HOUR_LIMIT;
            5: data = bcrtc_pkg::ALL_ONES;
            default: ;
         endcase
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'hBFFF, 16'hA000)), data);
      end else if (pick < 58) begin
         send_req(bcrtc_pkg::REQ_READ, 16'($urandom_range(16'hBFFF, 16'hA000)), data);
      end else if (pick < 66) begin
         send_req(bcrtc_pkg::REQ_READ, 16'($urandom_range(16'h7FFF, 16'h4000)), data);
      end else if (pick < 72) begin
         send_req(bcrtc_pkg::REQ_READ, 16'($urandom_range(16'hFFFF)), data);
      end else if (pick < 76) begin
         send_req(bcrtc_pkg::REQ_WRITE, 16'($urandom_range(16'hFFFF)), data);
      end else if (pick < 91) begin
         send_req(bcrtc_pkg::REQ_TICK_FWD, 16'($urandom_range(16'hFFFF)), data);
      end else begin
         send_req(bcrtc_pkg::REQ_TICK_BWD, 16'($urandom_range(16'hFFFF)), data);
      end
   endtask

   // stop offering, let every result come back and the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write, then read back
   task automatic write_option(bcrtc_pkg::csr_index_type idx, bit value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         bcrtc_pkg::CSR_HAS_RAM: opt_ram_fitted   = value;
         bcrtc_pkg::CSR_HAS_RTC: opt_clock_fitted = value;
         default:                opt_eight_banks  = value;
      endcase
      // back-to-back read setup
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(value)) begin
         $error("prdata: expected %0h, actual %0h", 32'(value), prdata);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   // receiver: random ready, or one long stall when asked
   always begin
      @(posedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         rsp_ready <= 1'b0;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 35);
      end
   end

   // every accepted result beat against the oldest prediction
   always @(posedge clock) begin : result_check
      bcrtc_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no prediction waiting: %p", rsp_payload);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.target !== want.target) begin
               $error("target: expected %0d, actual %0d", want.target, rsp_payload.target);
               fail_count++;
            end
            if (rsp_payload.bank !== want.bank) begin
               $error("bank: expected %0d, actual %0d", want.bank, rsp_payload.bank);
               fail_count++;
            end
            if (rsp_payload.offset !== want.offset) begin
               $error("offset: expected %0h, actual %0h", want.offset, rsp_payload.offset);
               fail_count++;
            end
            if (rsp_payload.read_data !== want.read_data) begin
               $error("read_data: expected %0h, actual %0h",
                      want.read_data, rsp_payload.read_data);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // mapping, enables, latch sequence, selector edges
   task automatic test_directed();
      send_req(bcrtc_pkg::REQ_READ,  16'h0000, 8'h00);   // fixed map, lowest address
      send_req(bcrtc_pkg::REQ_READ,  16'hFFFF, 8'hFF);   // fixed map, highest address
      send_req(bcrtc_pkg::REQ_READ,  16'h4000, 8'h00);   // rom bank 0 maps fixed
      send_req(bcrtc_pkg::REQ_READ,  16'hA000, 8'h00);   // ext window closed, zero
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, 8'hFF);   // ext write while closed
      send_req(bcrtc_pkg::REQ_WRITE, 16'h2000, 8'hFF);   // rom bank 0x7f, top bit masked
      send_req(bcrtc_pkg::REQ_READ,  16'h7FFF, 8'h00);   // last rom byte of top bank
      send_req(bcrtc_pkg::REQ_WRITE, 16'h3FFF, 8'h01);   // rom bank 1 still fixed
      send_req(bcrtc_pkg::REQ_READ,  16'h5000, 8'h00);
      send_req(bcrtc_pkg::REQ_READ,  16'h9FFF, 8'h00);   // just below ext window
      send_req(bcrtc_pkg::REQ_READ,  16'hC000, 8'h00);   // just above ext window
      send_req(bcrtc_pkg::REQ_WRITE, 16'h0000, 8'h0A);   // open ram and clock
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h03);   // last ram bank of four
      send_req(bcrtc_pkg::REQ_WRITE, 16'hBFFF, 8'h5A);
      send_req(bcrtc_pkg::REQ_READ,  16'hA000, 8'h00);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h5FFF, 8'h04);   // bank 4 invalid in four-bank part
      send_req(bcrtc_pkg::REQ_READ,  16'hB000, 8'h00);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h08);   // seconds
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, bcrtc_pkg::SEC_TOP);
      send_req(bcrtc_pkg::REQ_TICK_FWD, 16'hFFFF, 8'hFF); // seconds carry into minutes
      send_req(bcrtc_pkg::REQ_WRITE, 16'h6000, 8'h01);   // 1 without arming: no copy
      send_req(bcrtc_pkg::REQ_WRITE, 16'h6000, 8'h00);   // arm
      send_req(bcrtc_pkg::REQ_WRITE, 16'h7FFF, 8'h01);   // copy
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h09);   // minutes
      send_req(bcrtc_pkg::REQ_READ,  16'hA123, 8'h00);
      send_req(bcrtc_pkg::REQ_TICK_BWD, 16'h0000, 8'h00); // seconds borrow from minutes
      send_req(bcrtc_pkg::REQ_WRITE, 16'h1FFF, 8'h1B);   // non-key value closes both
      send_req(bcrtc_pkg::REQ_READ,  16'hA000, 8'h00);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h0D);   // selector past the clock bytes
   endtask

   // 23:59:59 on day 511 forward and back, plus an out of range seconds value
   task automatic test_clock_rollover();
      send_req(bcrtc_pkg::REQ_WRITE, 16'h0000, 8'hFA);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h08);
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, bcrtc_pkg::SEC_TOP);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h09);
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, bcrtc_pkg::MIN_TOP);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h0A);
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, bcrtc_pkg::HOUR_TOP);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h0B);
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, 8'hFF);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h0C);
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, 8'hFF);   // day bit 8 and all flag bits
      send_req(bcrtc_pkg::REQ_TICK_FWD, 16'h1234, 8'h00); // day wraps up to 0
      send_req(bcrtc_pkg::REQ_WRITE, 16'h6000, 8'h00);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h6000, 8'h01);
      for (int i = 8; i <= 12; i++) begin
         send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'(i));
         send_req(bcrtc_pkg::REQ_READ, 16'hBFFF, 8'h00);
      end
      send_req(bcrtc_pkg::REQ_TICK_BWD, 16'h4321, 8'hFF); // day wraps down to 511
      send_req(bcrtc_pkg::REQ_WRITE, 16'h6000, 8'h00);
      send_req(bcrtc_pkg::REQ_WRITE, 16'h6000, 8'h01);
      for (int i = 8; i <= 12; i++) begin
         send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'(i));
         send_req(bcrtc_pkg::REQ_READ, 16'hA000, 8'h00);
      end
      send_req(bcrtc_pkg::REQ_WRITE, 16'h4000, 8'h08);
      send_req(bcrtc_pkg::REQ_WRITE, 16'hA000, 8'd200);  // out of range seconds
      send_req(bcrtc_pkg::REQ_TICK_FWD, 16'h0000, 8'h00);
   endtask

   // random traffic under every combination of the cartridge options
   task automatic test_option_settings();
      for (int combo = 0; combo < 8; combo++) begin
         wait_drained();
         write_option(bcrtc_pkg::CSR_HAS_RAM,    combo[0]);
         write_option(bcrtc_pkg::CSR_HAS_RTC,    combo[1]);
         write_option(bcrtc_pkg::CSR_VARIANT_30, combo[2]);
         repeat (150) send_random();
      end
   endtask

   // long stretch with no idling on either side
   task automatic test_streaming();
      calm = 1'b1;
      repeat (200) send_random();
      calm = 1'b0;
   endtask

   // receiver stalls while beats keep coming, so req_ready has to drop
   task automatic test_backpressure();
      calm         = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_random();
      calm = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_clock_rollover();
      test_option_settings();
      test_streaming();
      test_backpressure();
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: bank_controller_with_rtc.f
rtl/bcrtc_pkg.sv
rtl/bank_controller_with_rtc.sv
tb/testbench.sv
